### src/hbs_pkg.sv
package hbs_pkg;

  localparam int MAX_SIDE      = 256;
  localparam int MAX_SUBSAMPLE = 16;
  localparam int STORE_DEPTH   = MAX_SIDE * MAX_SIDE;
  localparam int ADDR_W        = $clog2(STORE_DEPTH);
  localparam int SIDE_W        = 9;
  localparam int POS_W         = 8;
  localparam int STEP_W        = 5;
  localparam int COORD_W       = 12;
  localparam int VSIDE_W       = 13;
  localparam int SAMPLE_W      = 16;
  localparam int WEIGHT_W      = 9;
  localparam int SLOT_W        = 24;
  localparam int PROD_W        = 24;
  localparam int Q_W           = 32;
  localparam int DEN_W         = 25;
  localparam int NUM_W         = DEN_W + Q_W;
  localparam int RECIP_W       = 21;
  localparam int RECIP_SHIFT   = 20;
  localparam int DIV_STAGES    = 8;
  localparam int STEPS_PER_STG = Q_W / DIV_STAGES;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_SIDE   = 3'd0,
    CFG_SUB_SAMPLING = 3'd1,
    CFG_VERT_SIDE    = 3'd2,
    CFG_SCALE_Z      = 3'd3,
    CFG_INVERT       = 3'd4,
    CFG_FLIP_ROWS    = 3'd5,
    CFG_WIDE         = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic                query;
    logic [ADDR_W-1:0]   index;
    logic [SAMPLE_W-1:0] value;
    logic [COORD_W-1:0]  x;
    logic [COORD_W-1:0]  y;
  } req_t;

  typedef struct packed {
    logic [SIDE_W-1:0]  side;
    logic [STEP_W-1:0]  step;
    logic [VSIDE_W-1:0] vert_side;
    logic               flip;
  } coord_cfg_t;

  typedef struct packed {
    logic                          valid;
    logic                          query;
    logic [3:0][ADDR_W-1:0]        addr;
    logic [SAMPLE_W-1:0]           wdata;
    logic [3:0][WEIGHT_W-1:0]      weight;
    logic [SLOT_W-1:0]             slot;
  } fetch_t;

  // ceil(2^20 / s); exact floor division for 12-bit coordinates
  function automatic logic [RECIP_W-1:0] recip(input logic [STEP_W-1:0] s);
    logic [RECIP_W-1:0] r;
    case (s)
      5'd2:    r = 21'd524288;
      5'd3:    r = 21'd349526;
      5'd4:    r = 21'd262144;
      5'd5:    r = 21'd209716;
      5'd6:    r = 21'd174763;
      5'd7:    r = 21'd149797;
      5'd8:    r = 21'd131072;
      5'd9:    r = 21'd116509;
      5'd10:   r = 21'd104858;
      5'd11:   r = 21'd95326;
      5'd12:   r = 21'd87382;
      5'd13:   r = 21'd80660;
      5'd14:   r = 21'd74899;
      5'd15:   r = 21'd69906;
      5'd16:   r = 21'd65536;
      default: r = 21'd1048576;
    endcase
    return r;
  endfunction

endpackage

### src/hbs_ram.sv
module hbs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end
      rdata <= mem[addr];
    end
  end

endmodule

### src/hbs_coord.sv
module hbs_coord (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic               in_valid,
  input  hbs_pkg::req_t      in_req,
  input  hbs_pkg::coord_cfg_t cfg,
  output hbs_pkg::fetch_t    fetch
);
  import hbs_pkg::*;

  // stage 1: floor division by reciprocal, destination row product
  logic [32:0]         prod_x, prod_y;
  logic [SLOT_W-1:0]   row;
  logic                c1_valid;
  req_t                c1_req;
  logic [COORD_W-1:0]  c1_qx, c1_qy;
  logic [SLOT_W-1:0]   c1_rowm;

  assign prod_x = 33'(in_req.x) * 33'(recip(cfg.step));
  assign prod_y = 33'(in_req.y) * 33'(recip(cfg.step));
  assign row = cfg.flip ? (SLOT_W'(cfg.vert_side) - SLOT_W'(in_req.y) - SLOT_W'(1))
                        : SLOT_W'(in_req.y);

  always_ff @(posedge clk) begin
    if (rst) begin
      c1_valid <= 1'b0;
    end else if (adv) begin
      c1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c1_req  <= in_req;
      c1_qx   <= prod_x[RECIP_SHIFT +: COORD_W];
      c1_qy   <= prod_y[RECIP_SHIFT +: COORD_W];
      c1_rowm <= row * SLOT_W'(cfg.vert_side);
    end
  end

  // stage 2: remainders and edge clamp
  logic [COORD_W-1:0]  mx, my, rx_full, ry_full;
  logic [STEP_W-1:0]   rx, ry;
  logic [POS_W-1:0]    smax, x1, x2, y1, y2;
  logic [COORD_W:0]    qx2, qy2;
  logic                c2_valid;
  logic                c2_query;
  logic [ADDR_W-1:0]   c2_index;
  logic [SAMPLE_W-1:0] c2_value;
  logic [POS_W-1:0]    c2_x1, c2_x2, c2_y1, c2_y2;
  logic [STEP_W-1:0]   c2_rx, c2_ry;
  logic [SLOT_W-1:0]   c2_slot;

  assign mx      = c1_qx * COORD_W'(cfg.step);
  assign my      = c1_qy * COORD_W'(cfg.step);
  assign rx_full = c1_req.x - mx;
  assign ry_full = c1_req.y - my;
  assign rx      = rx_full[STEP_W-1:0];
  assign ry      = ry_full[STEP_W-1:0];
  assign smax    = POS_W'(cfg.side - SIDE_W'(1));
  assign qx2     = (COORD_W+1)'(c1_qx) + (COORD_W+1)'(rx != '0);
  assign qy2     = (COORD_W+1)'(c1_qy) + (COORD_W+1)'(ry != '0);
  assign x1      = (c1_qx > COORD_W'(smax)) ? smax : c1_qx[POS_W-1:0];
  assign y1      = (c1_qy > COORD_W'(smax)) ? smax : c1_qy[POS_W-1:0];
  assign x2      = (qx2 > (COORD_W+1)'(smax)) ? smax : qx2[POS_W-1:0];
  assign y2      = (qy2 > (COORD_W+1)'(smax)) ? smax : qy2[POS_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      c2_valid <= 1'b0;
    end else if (adv) begin
      c2_valid <= c1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c2_query <= c1_req.query;
      c2_index <= c1_req.index;
      c2_value <= c1_req.value;
      c2_x1    <= x1;
      c2_x2    <= x2;
      c2_y1    <= y1;
      c2_y2    <= y2;
      c2_rx    <= rx;
      c2_ry    <= ry;
      c2_slot  <= c1_rowm + SLOT_W'(c1_req.x);
    end
  end

  // stage 3: store addresses and blend weights
  logic [ADDR_W:0]     row1, row2;
  logic [ADDR_W:0]     a1, a2, a3, a4;
  logic [STEP_W-1:0]   sx, sy;
  logic [2*STEP_W-1:0] w1, w2, w3, w4;

  assign row1 = (ADDR_W+1)'(c2_y1) * (ADDR_W+1)'(cfg.side);
  assign row2 = (ADDR_W+1)'(c2_y2) * (ADDR_W+1)'(cfg.side);
  assign a1   = row1 + (ADDR_W+1)'(c2_x1);
  assign a2   = row1 + (ADDR_W+1)'(c2_x2);
  assign a3   = row2 + (ADDR_W+1)'(c2_x1);
  assign a4   = row2 + (ADDR_W+1)'(c2_x2);
  assign sx   = cfg.step - c2_rx;
  assign sy   = cfg.step - c2_ry;
  assign w1   = (2*STEP_W)'(sx) * (2*STEP_W)'(sy);
  assign w2   = (2*STEP_W)'(c2_rx) * (2*STEP_W)'(sy);
  assign w3   = (2*STEP_W)'(sx) * (2*STEP_W)'(c2_ry);
  assign w4   = (2*STEP_W)'(c2_rx) * (2*STEP_W)'(c2_ry);

  always_ff @(posedge clk) begin
    if (rst) begin
      fetch.valid <= 1'b0;
    end else if (adv) begin
      fetch.valid <= c2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fetch.query  <= c2_query;
      fetch.wdata  <= c2_value;
      fetch.slot   <= c2_slot;
      fetch.weight <= {w4[WEIGHT_W-1:0], w3[WEIGHT_W-1:0],
                       w2[WEIGHT_W-1:0], w1[WEIGHT_W-1:0]};
      if (c2_query) begin
        fetch.addr <= {a4[ADDR_W-1:0], a3[ADDR_W-1:0], a2[ADDR_W-1:0], a1[ADDR_W-1:0]};
      end else begin
        fetch.addr <= {c2_index, c2_index, c2_index, c2_index};
      end
    end
  end

`ifndef SYNTH
  // top-left sample never lies past bottom-right one
  a_corner_order: assert property (@(posedge clk) disable iff (rst)
    fetch.valid && fetch.query |-> fetch.addr[0] <= fetch.addr[3])
    else $error("corner addresses out of order");
`endif

endmodule

### src/hbs_div.sv
module hbs_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  logic                        in_valid,
  input  logic [hbs_pkg::NUM_W-1:0]   num,
  input  logic [hbs_pkg::DEN_W-1:0]   den,
  input  logic [hbs_pkg::SLOT_W-1:0]  in_slot,
  output logic                        out_valid,
  output logic [hbs_pkg::Q_W-1:0]     quo,
  output logic [hbs_pkg::SLOT_W-1:0]  out_slot
);
  import hbs_pkg::*;

  // restoring division, a few quotient bits per stage
  function automatic logic [DEN_W+2*Q_W-1:0] div_steps(
    input logic [DEN_W-1:0] r_in,
    input logic [Q_W-1:0]   lo_in,
    input logic [Q_W-1:0]   q_in,
    input logic [DEN_W-1:0] d
  );
    logic [DEN_W:0]   t;
    logic [DEN_W-1:0] r;
    logic [Q_W-1:0]   l;
    logic [Q_W-1:0]   q;
    r = r_in;
    l = lo_in;
    q = q_in;
    for (int i = 0; i < STEPS_PER_STG; i++) begin
      t = {r, l[Q_W-1]};
      l = {l[Q_W-2:0], 1'b0};
      if (t >= {1'b0, d}) begin
        t = t - {1'b0, d};
        q = {q[Q_W-2:0], 1'b1};
      end else begin
        q = {q[Q_W-2:0], 1'b0};
      end
      r = t[DEN_W-1:0];
    end
    return {r, l, q};
  endfunction

  logic                vv  [DIV_STAGES+1];
  logic [DEN_W-1:0]    rem [DIV_STAGES+1];
  logic [Q_W-1:0]      lo  [DIV_STAGES+1];
  logic [Q_W-1:0]      qq  [DIV_STAGES+1];
  logic [SLOT_W-1:0]   sl  [DIV_STAGES+1];

  assign vv[0]  = in_valid;
  assign rem[0] = num[NUM_W-1:Q_W];
  assign lo[0]  = num[Q_W-1:0];
  assign qq[0]  = '0;
  assign sl[0]  = in_slot;

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic [DEN_W+2*Q_W-1:0] nxt;

    assign nxt = div_steps(rem[k], lo[k], qq[k], den);

    always_ff @(posedge clk) begin
      if (rst) begin
        vv[k+1] <= 1'b0;
      end else if (adv) begin
        vv[k+1] <= vv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem[k+1] <= nxt[2*Q_W +: DEN_W];
        lo[k+1]  <= nxt[Q_W +: Q_W];
        qq[k+1]  <= nxt[Q_W-1:0];
        sl[k+1]  <= sl[k];
      end
    end
  end

  assign out_valid = vv[DIV_STAGES];
  assign quo       = qq[DIV_STAGES];
  assign out_slot  = sl[DIV_STAGES];

`ifndef SYNTH
  // quotient must fit the fixed quotient width
  a_quo_fits: assert property (@(posedge clk) disable iff (rst)
    in_valid |-> num[NUM_W-1:Q_W] < den)
    else $error("division overflow");
`endif

endmodule

### src/heightmap_bilinear_sampler.sv
// Bilinear heightmap sampler. Write requests (tuser 0) store one sample of a
// square image at its linear index; query requests (tuser 1) return the Q16.16
// height of one vertex, bilinearly blended from four samples, scaled and
// optionally inverted, with its destination slot. One request is taken every
// cycle while the output is not held, writes and queries alike: the sample
// store is kept as four identical single-port copies, so the four corner reads
// of a query happen in the same cycle. A query result passes through three
// address stages, the store read, three blend stages (weighting, sum and scale),
// one rounding stage, eight divider stages and the output register. Writes give
// no result and keep their order with queries. Reading a sample never written
// gives an undefined height. Write configuration only while the block is idle.
module heightmap_bilinear_sampler (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // sample_index, sample_value, vertex_x, vertex_y
  input  logic        s_tuser,   // action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // height, vertex_slot
  output logic        m_tuser,   // saturated
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import hbs_pkg::*;

  localparam logic signed [33:0] HMAX = 34'sh0_7FFF_FFFF;
  localparam logic signed [33:0] HMIN = -34'sh0_8000_0000;
  localparam logic signed [33:0] ONE  = 34'sd65536;

  // configuration
  logic [SIDE_W-1:0]     image_side;
  logic [STEP_W-1:0]     sub_sampling;
  logic [VSIDE_W-1:0]    vert_side;
  logic [CFG_DATA_W-1:0] scale_z;
  logic                  invert_height;
  logic                  flip_rows;
  logic                  wide_samples;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_side    <= SIDE_W'(MAX_SIDE);
      sub_sampling  <= STEP_W'(1);
      vert_side     <= VSIDE_W'(256);
      scale_z       <= 32'h0001_0000;
      invert_height <= 1'b0;
      flip_rows     <= 1'b0;
      wide_samples  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_IMAGE_SIDE:   image_side    <= cfg_data[SIDE_W-1:0];
        CFG_SUB_SAMPLING: sub_sampling  <= cfg_data[STEP_W-1:0];
        CFG_VERT_SIDE:    vert_side     <= cfg_data[VSIDE_W-1:0];
        CFG_SCALE_Z:      scale_z       <= cfg_data;
        CFG_INVERT:       invert_height <= cfg_data[0];
        CFG_FLIP_ROWS:    flip_rows     <= cfg_data[0];
        CFG_WIDE:         wide_samples  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic [SIDE_W-1:0]   side_c;
  logic [STEP_W-1:0]   step_c;
  logic [2*STEP_W-1:0] s2_full;
  logic [WEIGHT_W-1:0] s2;
  logic [PROD_W-1:0]   den0;
  logic [DEN_W-1:0]    den2;
  logic [Q_W-1:0]      mag;
  coord_cfg_t          ccfg;

  assign side_c  = (image_side == '0) ? SIDE_W'(1) :
                   (image_side > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : image_side;
  assign step_c  = (sub_sampling == '0) ? STEP_W'(1) :
                   (sub_sampling > STEP_W'(MAX_SUBSAMPLE)) ? STEP_W'(MAX_SUBSAMPLE)
                                                           : sub_sampling;
  assign s2_full = (2*STEP_W)'(step_c) * (2*STEP_W)'(step_c);
  assign s2      = s2_full[WEIGHT_W-1:0];
  // s^2 * 255 or s^2 * 65535
  assign den0    = wide_samples ? PROD_W'({s2, 16'b0} - {16'b0, s2})
                                : PROD_W'({s2, 8'b0} - {8'b0, s2});
  assign den2    = {den0, 1'b0};
  assign mag     = scale_z[Q_W-1] ? (~scale_z + Q_W'(1)) : scale_z;
  assign ccfg    = '{side: side_c, step: step_c, vert_side: vert_side, flip: flip_rows};

  // global advance: every stage moves unless the output is held
  logic adv;
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  req_t   in_req;
  fetch_t fetch;

  assign in_req = '{query: s_tuser, index: s_tdata[15:0], value: s_tdata[31:16],
                    x: s_tdata[43:32], y: s_tdata[55:44]};

  hbs_coord u_coord (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (s_tvalid),
    .in_req   (in_req),
    .cfg      (ccfg),
    .fetch    (fetch)
  );

  // sample store, one copy per corner
  logic [SAMPLE_W-1:0] rd [4];

  for (genvar i = 0; i < 4; i++) begin : g_store
    hbs_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (STORE_DEPTH)
    ) u_ram (
      .clk   (clk),
      .en    (adv),
      .we    (fetch.valid && !fetch.query),
      .addr  (fetch.addr[i]),
      .wdata (fetch.wdata),
      .rdata (rd[i])
    );
  end

  logic                     r_valid;
  logic [3:0][WEIGHT_W-1:0] r_weight;
  logic [SLOT_W-1:0]        r_slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (adv) begin
      r_valid <= fetch.valid && fetch.query;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r_weight <= fetch.weight;
      r_slot   <= fetch.slot;
    end
  end

  // weighted corners
  logic [SAMPLE_W-1:0]    samp [4];
  logic [PROD_W:0]        pf   [4];
  logic                   p_valid;
  logic [PROD_W-1:0]      p_term [4];
  logic [SLOT_W-1:0]      p_slot;

  for (genvar i = 0; i < 4; i++) begin : g_term
    assign samp[i] = wide_samples ? rd[i] : {8'b0, rd[i][7:0]};
    assign pf[i]   = (PROD_W+1)'(samp[i]) * (PROD_W+1)'(r_weight[i]);

    always_ff @(posedge clk) begin
      if (adv) begin
        p_term[i] <= pf[i][PROD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (adv) begin
      p_valid <= r_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_slot <= r_slot;
    end
  end

  // blend sum
  logic [PROD_W+1:0] sum_full;
  logic              s_valid;
  logic [PROD_W-1:0] s_prod;
  logic [SLOT_W-1:0] s_slot;

  assign sum_full = (PROD_W+2)'(p_term[0]) + (PROD_W+2)'(p_term[1])
                  + (PROD_W+2)'(p_term[2]) + (PROD_W+2)'(p_term[3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (adv) begin
      s_valid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s_prod <= sum_full[PROD_W-1:0];
      s_slot <= p_slot;
    end
  end

  // scale by |scale_z|
  logic                    m_valid;
  logic [PROD_W+Q_W-1:0]   m_pm;
  logic [SLOT_W-1:0]       m_slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (adv) begin
      m_valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_pm   <= (PROD_W+Q_W)'(s_prod) * (PROD_W+Q_W)'(mag);
      m_slot <= s_slot;
    end
  end

  // rounding numerator 2*P*|z| + den
  logic              n_valid;
  logic [NUM_W-1:0]  n_num;
  logic [SLOT_W-1:0] n_slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      n_valid <= 1'b0;
    end else if (adv) begin
      n_valid <= m_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n_num  <= {m_pm, 1'b0} + NUM_W'(den0);
      n_slot <= m_slot;
    end
  end

  logic              q_valid;
  logic [Q_W-1:0]    q_mag;
  logic [SLOT_W-1:0] q_slot;

  hbs_div u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (n_valid),
    .num       (n_num),
    .den       (den2),
    .in_slot   (n_slot),
    .out_valid (q_valid),
    .quo       (q_mag),
    .out_slot  (q_slot)
  );

  // sign, invert, saturate
  logic signed [33:0] vq, vi;
  logic               sat;
  logic [Q_W-1:0]     hgt;

  always_comb begin
    vq  = scale_z[Q_W-1] ? -$signed({2'b00, q_mag}) : $signed({2'b00, q_mag});
    vi  = invert_height ? (ONE - vq) : vq;
    sat = 1'b0;
    hgt = vi[Q_W-1:0];
    if (vi > HMAX) begin
      sat = 1'b1;
      hgt = 32'h7FFF_FFFF;
    end else if (vi < HMIN) begin
      sat = 1'b1;
      hgt = 32'h8000_0000;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= {q_slot, hgt};
      m_tuser <= sat;
    end
  end

`ifndef SYNTH
  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> (m_tdata[31:0] == 32'h7FFF_FFFF || m_tdata[31:0] == 32'h8000_0000))
    else $error("saturation flag without clipped height");

  // store read data must hold through a stall
  a_store_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(rd[0]))
    else $error("store output changed during stall");
`endif

endmodule

### tb/heightmap_bilinear_sampler_checker.sv
module heightmap_bilinear_sampler_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [55:0] s_tdata,
  input  logic        s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [55:0] m_tdata,
  input  logic        m_tuser,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          pending_heights
);
  import hbs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [31:0] height;
    logic [23:0] slot;
    logic        sat;
  } vertex_result_t;

  logic [15:0] samples [STORE_DEPTH];
  logic [8:0]  image_side;
  logic [4:0]  step_cfg;
  logic [12:0] vert_side;
  logic signed [31:0] scale_z;
  logic invert, flip, wide;
  vertex_result_t height_queue[$];

  function automatic logic [15:0] fetch_sample(int unsigned row, int unsigned col,
                                               int unsigned side);
    int unsigned a;
    a = row * side + col;
    if (a >= STORE_DEPTH) return 16'd0;
    return wide ? samples[a] : {8'd0, samples[a][7:0]};
  endfunction

  function automatic vertex_result_t blend_vertex(logic [11:0] x, logic [11:0] y);
    vertex_result_t r;
    int unsigned side, s, x1, x2, y1, y2, rx, ry;
    longint unsigned prod, mag, den, q;
    longint v;
    logic [31:0] row;
    side = image_side == 0 ? 1 : (image_side > MAX_SIDE ? MAX_SIDE : image_side);
    s = step_cfg == 0 ? 1 : (step_cfg > MAX_SUBSAMPLE ? MAX_SUBSAMPLE : step_cfg);
    x1 = x / s; rx = x % s; x2 = x1 + (rx != 0);
    y1 = y / s; ry = y % s; y2 = y1 + (ry != 0);
    if (x1 > side - 1) x1 = side - 1;
    if (x2 > side - 1) x2 = side - 1;
    if (y1 > side - 1) y1 = side - 1;
    if (y2 > side - 1) y2 = side - 1;
    prod = longint'(fetch_sample(y1, x1, side)) * (s - rx) * (s - ry)
         + longint'(fetch_sample(y1, x2, side)) * rx * (s - ry)
         + longint'(fetch_sample(y2, x1, side)) * (s - rx) * ry
         + longint'(fetch_sample(y2, x2, side)) * rx * ry;
    den = longint'(s) * s * (wide ? 65535 : 255);
    mag = scale_z < 0 ? longint'(-longint'(scale_z)) : longint'(scale_z);
    q = (2 * prod * mag + den) / (2 * den);
    v = scale_z < 0 ? -longint'(q) : longint'(q);
    if (invert) v = 65536 - v;
    r.sat = 1'b0;
    if (v > 64'sd2147483647) begin v = 64'sd2147483647; r.sat = 1'b1; end
    if (v < -64'sd2147483648) begin v = -64'sd2147483648; r.sat = 1'b1; end
    r.height = v[31:0];
    row = flip ? 32'(vert_side) - 32'(y) - 32'd1 : 32'(y);
    r.slot = 24'(row * 32'(vert_side) + 32'(x));
    return r;
  endfunction

  always @(posedge clk) begin
    vertex_result_t e;
    int errs;
    if (rst) begin
      image_side <= 9'd256; step_cfg <= 5'd1; vert_side <= 13'd256;
      scale_z <= 32'sd65536; invert <= 0; flip <= 0; wide <= 0;
      fail_count <= 0;
      height_queue.delete();
      pending_heights <= 0;
    end else begin
      errs = 0;
      if (cfg_we) begin
        case (cfg_index)
          CFG_IMAGE_SIDE:   image_side <= cfg_data[8:0];
          CFG_SUB_SAMPLING: step_cfg <= cfg_data[4:0];
          CFG_VERT_SIDE:    vert_side <= cfg_data[12:0];
          CFG_SCALE_Z:      scale_z <= cfg_data;
          CFG_INVERT:       invert <= cfg_data[0];
          CFG_FLIP_ROWS:    flip <= cfg_data[0];
          CFG_WIDE:         wide <= cfg_data[0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        if (!s_tuser) samples[s_tdata[15:0]] = s_tdata[31:16];
        else height_queue.push_back(blend_vertex(s_tdata[43:32], s_tdata[55:44]));
      end
      if (m_tvalid && m_tready) begin
        if (height_queue.size() == 0) begin
          $error("unexpected height result %h", m_tdata);
          errs = errs + 1;
        end else begin
          e = height_queue.pop_front();
          if (m_tdata[31:0] !== e.height) begin
            $error("height expected %h actual %h", e.height, m_tdata[31:0]);
            errs = errs + 1;
          end
          if (m_tdata[55:32] !== e.slot) begin
            $error("vertex_slot expected %h actual %h", e.slot, m_tdata[55:32]);
            errs = errs + 1;
          end
          if (m_tuser !== e.sat) begin
            $error("saturated expected %b actual %b", e.sat, m_tuser);
            errs = errs + 1;
          end
        end
      end
      fail_count <= fail_count + errs;
      pending_heights <= height_queue.size();
    end
  end
endmodule

### tb/heightmap_bilinear_sampler_test.sv
module heightmap_bilinear_sampler_test;
  import hbs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 0, rst = 1;
  logic s_tvalid = 0, s_tready, s_tuser = 0;
  logic [55:0] s_tdata = '0;
  logic m_tvalid, m_tready = 0, m_tuser;
  logic [55:0] m_tdata;
  logic cfg_we = 0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  int fail_count, pending_heights;
  int cycle_count = 0;
  bit stall_free;

  always begin #6 clk = 1; #6 clk = 0; end

  heightmap_bilinear_sampler u_dut (.*);
  heightmap_bilinear_sampler_checker u_check (.*);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("heightmap_bilinear_sampler test failed");
      $finish;
    end
  end

  function automatic int unsigned pick_gap();
    if (stall_free) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 100) < 60 ? 0 : $urandom_range(1, 3);
  endfunction

  always @(posedge clk) begin
    if (rst) m_tready <= 0;
    else if (stall_free) m_tready <= 1;
    else if ($urandom_range(0, 49) == 0) m_tready <= 0;
    else m_tready <= $urandom_range(0, 3) != 0;
  end

  task automatic send_request(logic act, logic [15:0] idx, logic [15:0] val,
                              logic [11:0] x, logic [11:0] y);
    int unsigned g;
    g = pick_gap();
    if (g > 0) begin
      s_tvalid <= 0;
      repeat (g) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tuser <= act;
    s_tdata <= {y, x, val, idx};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic write_reg(cfg_reg_t r, logic [31:0] d);
    cfg_we <= 1; cfg_index <= r; cfg_data <= d;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic drain();
    s_tvalid <= 0;
    @(posedge clk);
    while (pending_heights != 0) @(posedge clk);
    repeat (24) @(posedge clk);
  endtask

  // fill the top-left span x span corner of the image, stored with row stride eff
  task automatic fill_image(int unsigned eff, int unsigned span);
    for (int unsigned r = 0; r < span; r++)
      for (int unsigned c = 0; c < span; c++)
        send_request(0, 16'(r * eff + c), 16'($urandom), 12'($urandom), 12'($urandom));
  endtask

  task automatic run_phase(int unsigned side, int unsigned stp, int unsigned vs,
                           logic [31:0] sz, bit inv, bit fl, bit wd, int n);
    logic [11:0] x, y;
    int unsigned eff, est, span, lim;
    eff = side == 0 ? 1 : (side > MAX_SIDE ? MAX_SIDE : side);
    est = stp == 0 ? 1 : (stp > MAX_SUBSAMPLE ? MAX_SUBSAMPLE : stp);
    span = eff > 8 ? 8 : eff;
    // queries stay inside the written corner
    lim = span == eff ? eff * est - 1 : (span - 1) * est;
    if (lim > 4095) lim = 4095;
    drain();
    write_reg(CFG_IMAGE_SIDE, side);
    write_reg(CFG_SUB_SAMPLING, stp);
    write_reg(CFG_VERT_SIDE, vs);
    write_reg(CFG_SCALE_Z, sz);
    write_reg(CFG_INVERT, 32'(inv));
    write_reg(CFG_FLIP_ROWS, 32'(fl));
    write_reg(CFG_WIDE, 32'(wd));
    fill_image(eff, span);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0: send_request(0, 16'($urandom_range(0, eff * eff - 1)), 16'($urandom),
                        12'($urandom), 12'($urandom));
        1: begin
          // out of range or extreme coords, clamped, if span covers the image
          if (span == eff) begin
            x = $urandom_range(0, 1) ? 12'hfff : 12'($urandom);
            y = $urandom_range(0, 1) ? 12'hfff : 12'($urandom);
          end else begin
            x = 12'($urandom_range(0, lim));
            y = 12'($urandom_range(0, lim));
          end
          send_request(1, 16'($urandom), 16'($urandom), x, y);
        end
        default: begin
          x = 12'($urandom_range(0, lim));
          y = 12'($urandom_range(0, lim));
          send_request(1, 16'($urandom), 16'($urandom), x, y);
        end
      endcase
    end
  endtask

  initial begin
    stall_free = 0;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: reset-size image corners with defaults
    for (int i = 0; i < 4; i++)
      send_request(0, (i[0] ? 16'h00ff : 16'h0) | (i[1] ? 16'hff00 : 16'h0),
                   16'hffff, 12'd0, 12'd0);
    send_request(0, 16'h00ff + 16'h0100, 16'h1234, 0, 0);
    send_request(0, 16'h0001, 16'h00ab, 0, 0);
    send_request(0, 16'h0100, 16'hff00, 0, 0);
    send_request(0, 16'h0101, 16'h5a5a, 0, 0);
    send_request(1, 0, 0, 12'd0, 12'd0);
    send_request(1, 0, 0, 12'd255, 12'd255);
    send_request(1, 0, 0, 12'd255, 12'd0);
    send_request(1, 0, 0, 12'd0, 12'd255);
    send_request(1, 0, 0, 12'hfff, 12'hfff);
    send_request(1, 0, 0, 12'd1, 12'd1);
    // zero side and zero step act as one; tiny image
    run_phase(0, 0, 1, 32'h7fffffff, 0, 1, 1, 10);
    run_phase(1, 31, 8191, 32'h80000000, 1, 0, 1, 10);
    run_phase(2, 16, 4096, 32'hffff0000, 1, 1, 0, 40);
    run_phase(5, 3, 15, 32'($urandom), 0, 1, 1, 50);
    stall_free = 1;
    run_phase(4, 7, 28, 32'h00010000, 0, 0, 0, 40);
    stall_free = 0;
    run_phase(8, 1, 300, 32'($urandom), 1, 0, 1, 40);
    run_phase(6, 5, 30, 32'h00008000, 0, 1, 0, 40);
    run_phase(3, 2, 6, 32'h7fffffff, 1, 1, 1, 40);
    run_phase(300, 1, 256, 32'h00010000, 0, 0, 1, 40);
    drain();
    if (fail_count == 0) $display("heightmap_bilinear_sampler test passed");
    else $display("heightmap_bilinear_sampler test failed");
    $finish;
  end
endmodule

### filelist.f
src/hbs_pkg.sv
src/hbs_ram.sv
src/hbs_coord.sv
src/hbs_div.sv
src/heightmap_bilinear_sampler.sv
tb/heightmap_bilinear_sampler_checker.sv
tb/heightmap_bilinear_sampler_test.sv
